// ----- rtl/core/plvs_pkg.sv -----
// shared types and constants for the partitioned lru victim selector
`default_nettype none

package plvs_pkg;

    localparam int WAYS         = 16;
    localparam int HALF         = WAYS / 2;
    localparam int WAY_W        = 4;
    localparam int AGE_W        = 3;
    localparam int SLOT_W       = $clog2(HALF);
    localparam int ATT_W        = 3;
    localparam int LIMIT_W      = 4;
    localparam int MAX_ATTEMPTS = 8;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(1);

    localparam logic CMD_TOUCH  = 1'b0;
    localparam logic CMD_VICTIM = 1'b1;

    typedef struct packed {
        logic             cmd;
        logic             is_structure;
        logic [WAY_W-1:0] touched_way;
        logic [15:0]      valid_mask;
        logic [15:0]      replaceable_mask;
        logic [15:0]      lower_level_mask;
    } in_item_t;

    typedef struct packed {
        logic [WAY_W-1:0] way;
        logic [2:0]       prior_age;
        logic [2:0]       attempt_taken;
        logic             took_invalid;
    } out_item_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_UPDATE
    } state_t;

    typedef struct packed {
        logic load;
        logic search;
        logic update;
    } ctl_cmd_t;

    typedef struct packed {
        logic last;
    } ctl_sts_t;

endpackage

`default_nettype wire

// ----- rtl/core/plvs_ctrl.sv -----
// sequencer for touch and victim selection beats
`default_nettype none

module plvs_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic               in_cmd,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output plvs_pkg::ctl_cmd_t      ctl,
    input  wire plvs_pkg::ctl_sts_t sts
);
    import plvs_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   go;

    assign go        = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = (in_cmd == CMD_VICTIM) ? ST_SEARCH : ST_UPDATE;
                end
            end
            ST_SEARCH:
            begin
                state_next = ST_UPDATE;
            end
            ST_UPDATE:
            begin
                if (go)
                begin
                    state_next = sts.last ? ST_IDLE : ST_SEARCH;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        in_ready   = 1'b0;
        ctl.load   = 1'b0;
        ctl.search = 1'b0;
        ctl.update = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                ctl.load = in_valid;
            end
            ST_SEARCH:
            begin
                ctl.search = 1'b1;
            end
            ST_UPDATE:
            begin
                ctl.update = go;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        if (ctl.update && sts.last)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/plvs_datapath.sv -----
// age store, victim search and result register
`default_nettype none

module plvs_datapath (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire plvs_pkg::in_item_t              in_data,
    input  wire logic                            cfg_we,
    input  wire logic [plvs_pkg::LIMIT_W-1:0]    cfg_data,
    input  wire plvs_pkg::ctl_cmd_t              ctl,
    output plvs_pkg::ctl_sts_t                   sts,
    output plvs_pkg::out_item_t                  out_data
);
    import plvs_pkg::*;

    logic [AGE_W-1:0]   age_reg [WAYS];
    logic [AGE_W-1:0]   age_next [WAYS];
    in_item_t           item_reg;
    logic [WAY_W-1:0]   pick_reg;
    logic [WAY_W-1:0]   pick_next;
    logic               inv_reg;
    logic               inv_next;
    logic [ATT_W-1:0]   attempt_reg;
    logic [ATT_W-1:0]   attempt_next;
    logic [LIMIT_W-1:0] limit_reg;
    out_item_t          out_reg;

    logic [LIMIT_W-1:0] limit_eff;
    logic               last_attempt;
    logic [AGE_W-1:0]   pick_age;
    logic [AGE_W-1:0]   cand_age [HALF];
    logic [HALF-1:0]    cand_repl;
    logic [HALF-1:0]    cand_inv;
    logic               any_inv;
    logic [SLOT_W-1:0]  inv_slot;
    logic [SLOT_W-1:0]  max_slot;
    logic [AGE_W-1:0]   max_age;
    logic [WAY_W-1:0]   half_base;

    assign half_base = item_reg.is_structure ? WAY_W'(HALF) : '0;

    // effective attempt count, clamped to one..eight
    always_comb
    begin
        if (limit_reg == '0)
        begin
            limit_eff = LIMIT_W'(1);
        end
        else if (limit_reg > LIMIT_W'(MAX_ATTEMPTS))
        begin
            limit_eff = LIMIT_W'(MAX_ATTEMPTS);
        end
        else
        begin
            limit_eff = limit_reg;
        end
    end

    assign last_attempt = ({1'b0, attempt_reg} + LIMIT_W'(1)) >= limit_eff;
    assign pick_age     = age_reg[pick_reg];

    // candidates of the selected half
    always_comb
    begin
        for (int j = 0; j < HALF; j++)
        begin
            cand_age[j]  = item_reg.is_structure ? age_reg[j + HALF] : age_reg[j];
            cand_repl[j] = item_reg.replaceable_mask[half_base + WAY_W'(j)];
            cand_inv[j]  = !item_reg.valid_mask[half_base + WAY_W'(j)];
        end
    end

    // lowest invalid way
    always_comb
    begin
        any_inv  = |cand_inv;
        inv_slot = '0;
        for (int j = HALF - 1; j >= 0; j--)
        begin
            if (cand_inv[j])
            begin
                inv_slot = SLOT_W'(j);
            end
        end
    end

    // oldest replaceable way, first one wins on a tie
    always_comb
    begin
        max_slot = '0;
        max_age  = '0;
        for (int j = 0; j < HALF; j++)
        begin
            if (cand_repl[j] && (cand_age[j] > max_age))
            begin
                max_slot = SLOT_W'(j);
                max_age  = cand_age[j];
            end
        end
    end

    always_comb
    begin
        pick_next    = pick_reg;
        inv_next     = inv_reg;
        attempt_next = attempt_reg;
        if (ctl.load)
        begin
            pick_next    = in_data.touched_way;
            inv_next     = 1'b0;
            attempt_next = '0;
        end
        else if (ctl.search)
        begin
            inv_next  = any_inv;
            pick_next = half_base + WAY_W'(any_inv ? inv_slot : max_slot);
        end
        else if (ctl.update && !sts.last)
        begin
            attempt_next = attempt_reg + ATT_W'(1);
        end
    end

    assign sts.last = (item_reg.cmd == CMD_TOUCH) || inv_reg || last_attempt
                      || !item_reg.lower_level_mask[pick_reg];

    // make the picked way mru within the selected half
    always_comb
    begin
        for (int i = 0; i < WAYS; i++)
        begin
            age_next[i] = age_reg[i];
            if (ctl.update)
            begin
                if (WAY_W'(i) == pick_reg)
                begin
                    age_next[i] = '0;
                end
                else if (((i >= HALF) == item_reg.is_structure) && (age_reg[i] < pick_age))
                begin
                    age_next[i] = age_reg[i] + AGE_W'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < WAYS; i++)
            begin
                age_reg[i] <= AGE_W'(i % HALF);
            end
            limit_reg   <= LIMIT_RESET;
            inv_reg     <= 1'b0;
            attempt_reg <= '0;
        end
        else
        begin
            age_reg     <= age_next;
            inv_reg     <= inv_next;
            attempt_reg <= attempt_next;
            if (cfg_we)
            begin
                limit_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        pick_reg <= pick_next;
        if (ctl.load)
        begin
            item_reg <= in_data;
        end
        if (ctl.update && sts.last)
        begin
            out_reg.way           <= pick_reg;
            out_reg.prior_age     <= (item_reg.cmd == CMD_TOUCH) ? 3'(pick_age) : 3'd0;
            out_reg.attempt_taken <= 3'(attempt_reg);
            out_reg.took_invalid  <= inv_reg;
        end
    end

    assign out_data = out_reg;

endmodule

`default_nettype wire

// ----- rtl/core/partitioned_lru_victim_select.sv -----
// top level of the partitioned lru victim selector
`default_nettype none

// Keeps the lru ages of one sixteen-way set split into a lower half (ordinary
// data) and an upper half (structure data). A touch passes from the accepted
// beat through the idle state, which accepts it, and the update state, which
// updates the ages, to the result register. A victim request goes through
// idle, search and update, and repeats search and update for each further
// attempt until an invalid way is found, an attempt is accepted or the limit
// of at most eight attempts is reached; the search-then-age loop works over
// the age registers, one half at a time. A new request beat is taken as soon
// as the previous one has reached the result register, which holds it until
// the out beat completes. The attempt_limit register is written through the
// cfg channel, which is always ready.
module partitioned_lru_victim_select (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         in_valid,
    output logic                              in_ready,
    input  wire plvs_pkg::in_item_t           in_data,
    output logic                              out_valid,
    input  wire logic                         out_ready,
    output plvs_pkg::out_item_t               out_data,
    input  wire logic                         cfg_valid,
    output logic                              cfg_ready,
    input  wire logic [plvs_pkg::LIMIT_W-1:0] cfg_data
);
    import plvs_pkg::*;

    ctl_cmd_t ctl;
    ctl_sts_t sts;

    assign cfg_ready = 1'b1;

    plvs_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_cmd    (in_data.cmd),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .ctl       (ctl),
        .sts       (sts)
    );

    plvs_datapath u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_data  (in_data),
        .cfg_we   (cfg_valid && cfg_ready),
        .cfg_data (cfg_data),
        .ctl      (ctl),
        .sts      (sts),
        .out_data (out_data)
    );

endmodule

`default_nettype wire
